/* design/aes_block_cipher_macros.svh */
// Assertion macros for the AES block cipher.
// No dependencies; included by the top level.
`ifndef AES_BLOCK_CIPHER_MACROS_SVH
`define AES_BLOCK_CIPHER_MACROS_SVH

// implication checked on every clock edge outside reset
`define AES_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/aes_pkg.sv */
// Package for the AES block cipher: S-box tables, GF helpers, round functions.
// No dependencies.
`default_nettype none
package aes_pkg;

    localparam int RK_WORDS   = 60;
    localparam int RK_ROWS    = RK_WORDS / 4;
    localparam int RK_AW      = 6;
    localparam int ROUND_W    = 4;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;
    localparam logic [1:0] KEY_256 = 2'd2;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    typedef logic [127:0] t_block;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte index i = r + 4c, held at bits 127-8i
    function automatic logic [7:0] gb(input t_block s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    function automatic t_block enc_round(input t_block s, input logic last);
        t_block t;
        t_block m;
        logic [7:0] a0, a1, a2, a3;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127 - 8*(r+4*c) -: 8] = SBOX[gb(s, r + 4*((c+r)%4))];
        for (int c = 0; c < 4; c++) begin
            a0 = gb(t, 4*c); a1 = gb(t, 4*c+1); a2 = gb(t, 4*c+2); a3 = gb(t, 4*c+3);
            m[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            m[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            m[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return last ? t : m;
    endfunction

    function automatic logic [7:0] gm(input logic [7:0] x, input logic [3:0] y);
        logic [7:0] acc;
        logic [7:0] v;
        acc = 8'h00;
        v = x;
        for (int b = 0; b < 4; b++) begin
            if (y[b]) acc = acc ^ v;
            v = xt(v);
        end
        return acc;
    endfunction

    function automatic t_block inv_mix(input t_block s);
        t_block m;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = gb(s, 4*c); a1 = gb(s, 4*c+1); a2 = gb(s, 4*c+2); a3 = gb(s, 4*c+3);
            m[127-8*(4*c)   -: 8] = gm(a0,4'd14)^gm(a1,4'd11)^gm(a2,4'd13)^gm(a3,4'd9);
            m[127-8*(4*c+1) -: 8] = gm(a0,4'd9)^gm(a1,4'd14)^gm(a2,4'd11)^gm(a3,4'd13);
            m[127-8*(4*c+2) -: 8] = gm(a0,4'd13)^gm(a1,4'd9)^gm(a2,4'd14)^gm(a3,4'd11);
            m[127-8*(4*c+3) -: 8] = gm(a0,4'd11)^gm(a1,4'd13)^gm(a2,4'd9)^gm(a3,4'd14);
        end
        return m;
    endfunction

    // inverse shift rows then inverse sub bytes
    function automatic t_block dec_sub(input t_block s);
        t_block t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127 - 8*(r + 4*((c+r)%4)) -: 8] = ISBOX[gb(s, r + 4*c)];
        return t;
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage
`default_nettype wire

/* design/aes_key_exp.sv */
// Key schedule sequencer: one round-key word per cycle into a row memory.
// Depends on aes_pkg.
`default_nettype none
module aes_key_exp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [1:0]                  i_mode,
    input  wire logic [255:0]                i_key,
    input  wire logic [aes_pkg::ROUND_W-1:0] i_rd_row,
    output logic [127:0]                     o_rd_data,
    output logic                             o_busy
);
    import aes_pkg::*;

    logic [127:0]      r_mem [RK_ROWS]; // one round a row, lowest word on top
    logic [RK_AW-1:0]  r_idx;
    logic [RK_AW-1:0]  n_idx;
    logic              r_busy;
    logic [RK_AW-1:0]  r_k;     // position inside current nk group
    logic [7:0]        r_rcon;
    logic [RK_AW-1:0]  r_ng;
    logic [31:0]       r_win [8]; // last nk words, newest at 0
    logic [RK_AW-1:0]  total;
    logic [31:0]       prev, back, tw, wnew, kword;
    logic [1:0]        m;

    assign m     = (i_mode == 2'd3) ? KEY_256 : i_mode;
    assign total = (m == KEY_128) ? RK_AW'(44) :
                   ((m == KEY_192) ? RK_AW'(52) : RK_AW'(RK_WORDS));

    assign prev  = r_win[0];
    assign back  = (m == KEY_128) ? r_win[3] : ((m == KEY_192) ? r_win[5] : r_win[7]);
    assign kword = i_key[255 - 32*r_idx[2:0] -: 32];

    always_comb begin
        tw = prev;
        if (r_k == '0)
            tw = subst_word({prev[23:0], prev[31:24]}) ^ {r_rcon, 24'h0};
        else if (m != KEY_128 && m != KEY_192 && r_k == RK_AW'(4))
            tw = subst_word(prev);
        wnew  = back ^ tw;
        n_idx = r_idx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= n_idx;
            if (n_idx == total) r_busy <= 1'b0;
        end
    end

    // key words go in first, shifting through the window as they are stored
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k    <= '0;
            r_rcon <= 8'h01;
            r_ng   <= RK_AW'((m == KEY_128) ? 4 : ((m == KEY_192) ? 6 : 8));
        end else if (r_busy) begin
            for (int j = 1; j < 8; j++) r_win[j] <= r_win[j-1];
            if (r_idx < r_ng) begin
                r_mem[r_idx[RK_AW-1:2]][127 - 32*r_idx[1:0] -: 32] <= kword;
                r_win[0] <= kword;
            end else begin
                r_mem[r_idx[RK_AW-1:2]][127 - 32*r_idx[1:0] -: 32] <= wnew;
                r_win[0] <= wnew;
                if (r_k == r_ng - 1'b1) begin
                    r_k    <= '0;
                    r_rcon <= xt(r_rcon);
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    // round key read: one row of four words, registered
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_row];
    end

    assign o_busy = r_busy | i_start;
endmodule
`default_nettype wire

/* design/aes_block_cipher.sv */
// AES-128/192/256 single-block cipher top level: APB key registers, key schedule,
// iterative round unit. Depends on aes_pkg, aes_key_exp, aes_block_cipher_macros.svh.
//
//  port group   | dir | handshake       | carries
//  -------------|-----|-----------------|-------------------------------
//  config (APB) | in  | psel/penable    | key_size_mode, key words 0..3
//  input word   | in  | valid/ready     | cmd, block_hi, block_lo
//  result word  | out | valid/ready     | result_hi, result_lo
//
// One round per cycle through a single shared round unit: key fetch, load with the
// first key, 10/12/14 rounds, hand-over to the output register; a new word is taken
// only once the previous one has been handed over.
// After reset or any write to the mode or key registers the first word first waits
// for the key schedule, which stores one key word per cycle.
// Reset is synchronous, active low. A stalled result sits in the output register;
// the next word still runs and waits at hand-over only if that register is full.
`default_nettype none
`include "aes_block_cipher_macros.svh"
module aes_block_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [63:0] i_block_hi,
    input  wire logic [63:0] i_block_lo,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_result_hi,
    output logic [63:0]      o_result_lo
);
    import aes_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXP  = 3'd1;
    localparam logic [2:0] ST_KEY  = 3'd2; // first round key being fetched
    localparam logic [2:0] ST_LOAD = 3'd3; // first key added, next one fetched
    localparam logic [2:0] ST_RND  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_K0   = 3'd1;
    localparam logic [2:0] REG_K1   = 3'd2;
    localparam logic [2:0] REG_K2   = 3'd3;
    localparam logic [2:0] REG_K3   = 3'd4;

    logic [1:0]   r_mode;
    logic [63:0]  r_key [4];
    logic         r_expanded;
    logic [2:0]   r_state;
    logic         r_dec;
    t_block       r_s;
    t_block       r_in;
    t_block       r_out;
    logic         r_ovalid;
    logic         out_load;
    logic [ROUND_W-1:0] r_rnd;
    logic [ROUND_W-1:0] nr;
    logic [ROUND_W-1:0] rd_row;
    logic [127:0] rk;
    logic         exp_start, exp_busy, wr;
    logic [2:0]   reg_idx;
    t_block       rnd_out, dsub;
    logic [ROUND_W-1:0] n_rnd;

    assign pready  = 1'b1;
    assign wr      = psel & penable & pwrite;
    assign reg_idx = paddr[5:3];

    always_comb begin
        unique case (reg_idx)
            REG_MODE: prdata = {62'd0, r_mode};
            REG_K0:   prdata = r_key[0];
            REG_K1:   prdata = r_key[1];
            REG_K2:   prdata = r_key[2];
            REG_K3:   prdata = r_key[3];
            default:  prdata = '0;
        endcase
    end

    // register writes; any in-range write forces a fresh key schedule
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= KEY_128;
            for (int j = 0; j < 4; j++) r_key[j] <= '0;
            r_expanded <= 1'b0;
        end else if (wr && reg_idx <= REG_K3) begin
            if (reg_idx == REG_MODE) r_mode <= pwdata[1:0];
            else r_key[reg_idx[1:0] - 2'd1] <= pwdata;
            r_expanded <= 1'b0;
        end else if (r_state == ST_EXP && !exp_busy) begin
            r_expanded <= 1'b1;
        end
    end

    assign nr = (r_mode == KEY_128) ? 4'd10 : ((r_mode == KEY_192) ? 4'd12 : 4'd14);
    assign o_ready   = (r_state == ST_IDLE);
    assign exp_start = (r_state == ST_IDLE) && i_valid && !r_expanded;

    // the key memory read is registered: fetch one round ahead
    assign n_rnd  = r_dec ? r_rnd - 1'b1 : r_rnd + 1'b1;
    assign rd_row = (r_state == ST_RND || r_state == ST_LOAD) ? n_rnd : r_rnd;

    aes_key_exp u_kexp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (exp_start),
        .i_mode    (r_mode),
        .i_key     ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_rd_row  (rd_row),
        .o_rd_data (rk),
        .o_busy    (exp_busy)
    );

    // shared round unit: encrypt rounds run SubBytes/ShiftRows/MixColumns then the key;
    // decrypt runs InvShiftRows/InvSubBytes, key, InvMixColumns; no mix in last rounds
    assign dsub = dec_sub(r_s);
    always_comb begin
        if (!r_dec) rnd_out = enc_round(r_s, r_rnd == nr) ^ rk;
        else if (r_rnd == '0) rnd_out = dsub ^ rk;
        else rnd_out = inv_mix(dsub ^ rk);
    end

    // hand-over into the output register once it is free or being emptied
    assign out_load = (r_state == ST_OUT) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_in  <= {i_block_hi, i_block_lo};
                    r_dec <= (i_cmd == CMD_DEC);
                    r_rnd <= (i_cmd == CMD_DEC) ? nr : '0;
                    r_state <= r_expanded ? ST_KEY : ST_EXP;
                end
                ST_EXP: if (!exp_busy) r_state <= ST_KEY;
                ST_KEY: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_rnd   <= n_rnd;
                    r_state <= ST_RND;
                end
                ST_RND: begin
                    r_rnd <= n_rnd;
                    if ((!r_dec && r_rnd == nr) || (r_dec && r_rnd == '0))
                        r_state <= ST_OUT;
                end
                ST_OUT: if (out_load) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // state register: the first key (round 0 or nr) is added as the load step
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            r_s <= r_in ^ rk;
        end else if (r_state == ST_RND) begin
            r_s <= rnd_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= r_s;
    end

    assign o_valid     = r_ovalid;
    assign o_result_hi = r_out[127:64];
    assign o_result_lo = r_out[63:0];

    `AES_ASSERT_IMPL(a_out_hold, o_valid && !i_ready, ##1 o_valid, "result dropped while stalled")
    `AES_ASSERT_NEXT(a_out_stable, o_valid && !i_ready, $stable(o_result_hi) && $stable(o_result_lo), "result changed while stalled")
    `AES_ASSERT_NEXT(a_exp_go, exp_start, r_state == ST_EXP, "key schedule not entered")
endmodule
`default_nettype wire

/* sim/aes_block_cipher_test.sv */
// Testbench for aes_block_cipher: APB key set-up, random enciphering and
// deciphering of blocks, results checked against a built-in AES predictor.
// Depends on aes_pkg (key-size and command codes) and the RTL only.
`timescale 1ns / 100ps
`default_nettype none
module aes_block_cipher_test;
    import aes_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int N_RANDOM     = 1750;

    // register addresses, 64-bit registers so 8 bytes apart
    localparam logic [5:0] ADDR_MODE = 6'd0;
    localparam logic [5:0] ADDR_KEY0 = 6'd8;
    localparam logic [5:0] ADDR_KEY1 = 6'd16;
    localparam logic [5:0] ADDR_KEY2 = 6'd24;
    localparam logic [5:0] ADDR_KEY3 = 6'd32;

    typedef struct packed {
        logic        cmd;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = 1'b0;
    logic [63:0] i_block_hi = '0, i_block_lo = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_result_hi, o_result_lo;

    aes_block_cipher u_dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state: its own copy of the key registers and schedule
    logic [1:0]  key_mode = KEY_128;
    logic [63:0] key_reg [4] = '{default: '0};
    logic [31:0] sched [60];
    logic [7:0]  sbox_tab [256];
    logic [7:0]  isbox_tab [256];

    t_word       word_q [$];
    logic [127:0] expect_q [$];
    int          n_fail = 0, n_checked = 0, n_sent = 0, cycles = 0;
    int          n_dec = 0;
    logic        driving_done = 1'b0;

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        acc = 0;
        for (int b = 0; b < 8; b++) begin
            if (y[b]) acc ^= x;
            x = dbl(x);
        end
        return acc;
    endfunction

    // S-box built from the field inverse and affine map
    function automatic void build_sboxes();
        logic [7:0] inv, s;
        for (int x = 0; x < 256; x++) begin
            inv = 0;
            for (int y = 1; y < 256; y++)
                if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox_tab[x] = s;
            isbox_tab[s] = x[7:0];
        end
    endfunction

    function automatic int nk_words();
        return (key_mode == KEY_128) ? 4 : (key_mode == KEY_192) ? 6 : 8;
    endfunction

    function automatic logic [31:0] subw(input logic [31:0] w);
        return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        int nk;
        logic [31:0] t;
        logic [7:0] rc;
        nk = nk_words();
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
        rc = 8'h01;
        for (int i = nk; i < 4 * (nk + 7); i++) begin
            t = sched[i-1];
            if (i % nk == 0) begin
                t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = dbl(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = subw(t);
            end
            sched[i] = sched[i-nk] ^ t;
        end
    endfunction

    function automatic logic [127:0] add_rk(input logic [127:0] s, input int r);
        return s ^ {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
    endfunction

    // byte i (row i%4, column i/4) sits at bits 127-8i
    function automatic logic [127:0] shift_sub(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (inv)
                    t[127-8*(r+4*((c+r)%4)) -: 8] = isbox_tab[s[127-8*(r+4*c) -: 8]];
                else
                    t[127-8*(r+4*c) -: 8] = sbox_tab[s[127-8*(r+4*((c+r)%4)) -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
        logic [127:0] m;
        logic [7:0] coef [4];
        logic [7:0] v;
        if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                v = 0;
                for (int k = 0; k < 4; k++)
                    v ^= gmul(s[127-8*(4*c+k) -: 8], coef[(k-r+4)%4]);
                m[127-8*(4*c+r) -: 8] = v;
            end
        return m;
    endfunction

    function automatic logic [127:0] cipher_block(input t_word w);
        logic [127:0] s;
        int nr;
        nr = nk_words() + 6;
        s = {w.hi, w.lo};
        if (w.cmd == CMD_ENC) begin
            s = add_rk(s, 0);
            for (int r = 1; r < nr; r++) s = add_rk(mix(shift_sub(s, 0), 0), r);
            s = add_rk(shift_sub(s, 0), nr);
        end else begin
            s = add_rk(s, nr);
            for (int r = nr - 1; r > 0; r--) s = mix(add_rk(shift_sub(s, 1), r), 1);
            s = add_rk(shift_sub(s, 1), 0);
        end
        return s;
    endfunction

    // driver: bursts of words with random gaps
    int gap_left = 0, burst_left = 0;
    always @(posedge i_clk) begin
        t_word w;
        cycles <= cycles + 1;
        if (i_valid && o_ready) begin
            expect_q.push_back(cipher_block(word_q.pop_front()));
            n_sent <= n_sent + 1;
        end
        if (!i_valid || o_ready) begin
            if (gap_left > 0 || word_q.size() == 0 || !i_rst_n || driving_done) begin
                i_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                w = word_q[0];
                i_valid    <= 1'b1;
                i_cmd      <= w.cmd;
                i_block_hi <= w.hi;
                i_block_lo <= w.lo;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(30);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor: receiver stalls in its own rhythm, sometimes not at all
    int stall_mode = 0;
    always @(posedge i_clk) begin
        logic [127:0] exp_blk;
        if (cycles % 500 == 0) stall_mode <= $urandom_range(2);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(3) != 0);
            default: i_ready <= (cycles % 23 > 15);
        endcase
        if (o_valid && i_ready && i_rst_n) begin
            if (expect_q.size() == 0) begin
                n_fail <= n_fail + 1;
                if (n_fail < 10) $display("unexpected result word %h %h", o_result_hi, o_result_lo);
            end else begin
                exp_blk = expect_q.pop_front();
                n_checked <= n_checked + 1;
                if ({o_result_hi, o_result_lo} !== exp_blk) begin
                    n_fail <= n_fail + 1;
                    if (n_fail < 10)
                        $display("mismatch: exp hi %h lo %h, got hi %h lo %h",
                                 exp_blk[127:64], exp_blk[63:0], o_result_hi, o_result_lo);
                end
            end
        end
    end

    always @(posedge i_clk)
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end

    task automatic reg_write(input logic [5:0] addr, input logic [63:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_MODE) key_mode = (data[1:0] == 2'd3) ? KEY_256 : data[1:0];
        else key_reg[addr/8 - 1] = data;
    endtask

    // new key set-up; the schedule is recomputed up front, as any write forces
    // the block to re-expand before the next word
    task automatic load_key(input logic [1:0] mode, input logic [63:0] k0, k1, k2, k3);
        reg_write(ADDR_MODE, {62'd0, mode});
        reg_write(ADDR_KEY0, k0);
        reg_write(ADDR_KEY1, k1);
        reg_write(ADDR_KEY2, k2);
        reg_write(ADDR_KEY3, k3);
        expand_schedule();
    endtask

    task automatic drain();
        while (word_q.size() != 0 || i_valid || expect_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_word make_word(input logic c, input logic [63:0] h, l);
        t_word w;
        w.cmd = c; w.hi = h; w.lo = l;
        return w;
    endfunction

    initial begin
        int n_phase;
        build_sboxes();
        expand_schedule();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key (all zero, 128-bit) with field extremes both ways
        word_q.push_back(make_word(CMD_ENC, '0, '0));
        word_q.push_back(make_word(CMD_DEC, '0, '0));
        word_q.push_back(make_word(CMD_ENC, '1, '1));
        word_q.push_back(make_word(CMD_DEC, '1, '1));
        drain();

        // standard example keys, each key size, then mode three acting as 256
        load_key(KEY_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        word_q.push_back(make_word(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff));
        word_q.push_back(make_word(CMD_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a));
        drain();
        load_key(KEY_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, '1);
        word_q.push_back(make_word(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff));
        word_q.push_back(make_word(CMD_DEC, '1, '0));
        drain();
        load_key(2'd3, '1, '1, '1, '1);
        word_q.push_back(make_word(CMD_ENC, '0, '1));
        word_q.push_back(make_word(CMD_DEC, 64'h8000000000000001, 64'h0123456789abcdef));
        drain();

        // random phases: random key, key sizes in rotation, a run of random words
        n_phase = 0;
        while (n_sent < N_RANDOM + 10) begin
            case (n_phase % 4)
                0: load_key(KEY_128, rnd64(), rnd64(), rnd64(), rnd64());
                1: load_key(KEY_192, rnd64(), rnd64(), rnd64(), rnd64());
                2: load_key(KEY_256, rnd64(), rnd64(), rnd64(), rnd64());
                default: load_key(2'd3, '0, rnd64(), '1, rnd64());
            endcase
            repeat ($urandom_range(150, 40)) begin
                word_q.push_back(make_word($urandom_range(1), rnd64(), rnd64()));
                if (word_q[$].cmd == CMD_DEC) n_dec++;
            end
            drain();
            n_phase++;
        end
        driving_done = 1'b1;

        $display("%0d words checked (%0d random decrypts), %0d key phases over all key sizes",
                 n_checked, n_dec, n_phase + 4);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d failures", n_fail);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+design
design/aes_pkg.sv
design/aes_key_exp.sv
design/aes_block_cipher.sv
sim/aes_block_cipher_test.sv
